@@ rtl/imm_pkg.sv @@
`timescale 1ns / 1ps

package imm_pkg;

    // Matrix dimensions
    localparam int ROWS_A    = 16;
    localparam int INNER_MAX = 16;
    localparam int COLS_B    = 16;

    localparam int A_DEPTH  = ROWS_A * INNER_MAX;
    localparam int B_DEPTH  = INNER_MAX * COLS_B;
    localparam int A_ADDR_W = $clog2(A_DEPTH);
    localparam int B_ADDR_W = $clog2(B_DEPTH);

    // Inner index and inner count widths
    localparam int K_W     = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
    localparam int K_CNT_W = $clog2(INNER_MAX + 1);

    // Field widths
    localparam int TYPE_W = 2;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_INNER_LENGTH = REG_IDX_W'(0);
    localparam logic [LEN_W-1:0]     INNER_LENGTH_RESET = LEN_W'(16);

    // Request types on the input channel
    localparam logic [TYPE_W-1:0] REQ_WRITE_A = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE_B = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_COMPUTE = 2'd2;

    // Classified operations in the queue
    localparam logic [1:0] OP_WR_A = 2'd0;
    localparam logic [1:0] OP_WR_B = 2'd1;
    localparam logic [1:0] OP_CALC = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         column_index;
        logic signed [DATA_W-1:0] element_value;
    } imm_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]         result_row;
        logic [IDX_W-1:0]         result_column;
        logic signed [DATA_W-1:0] dot_sum;
    } imm_out_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              in_range;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } imm_cmd_t;

    typedef struct packed {
        logic busy;
        logic mac_active;
    } imm_back_stat_t;

endpackage

@@ rtl/integer_matrix_multiply_unit.sv @@
`timescale 1ns / 1ps

// Integer matrix multiply unit: holds A (16x16) and B (16x16) of signed 32-bit
// elements in two block RAMs and returns single elements of C = A * B.
// Input channel (item_valid / item_stall / item): req_type 0 writes A[row][col],
// 1 writes B[row][col], 2 asks for C[row][col]; type 3 is dropped. A transfer
// takes place when item_valid is high and item_stall is low.
// Output channel (result_valid / result_stall / result) carries one result per
// compute request, in request order, with the sum wrapped to 32 bits.
// A two-entry command queue parts the input from the MAC engine, so items are
// taken while the engine runs or a result waits on a stalled receiver.
// A write is done in the cycle it leaves the queue. A compute request runs
// over n inner terms, n being inner_length capped at 16; the engine takes the
// next command in the cycle result_valid rises. The time is set by the single
// multiply-accumulate unit: one RAM read per inner term, then a registered
// multiply and a registered add. inner_length is written over the APB port at
// address 0; the user must write it only while the unit is idle, which the
// block itself does not enforce.
// Reset clears the queue, the engine and the output valid flag and sets
// inner_length to 16; store contents are undefined until written.
// A stalled result holds in the output register; the engine waits with the
// next sum until that register frees, and the queue fills and raises item_stall.

module integer_matrix_multiply_unit
    import imm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  imm_in_t            item,
    output logic               result_valid,
    input  logic               result_stall,
    output imm_out_t           result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LEN_W-1:0] inner_length_reg, inner_length_next;
    logic             cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic             cmd_valid;
    imm_cmd_t         cmd;
    logic             cmd_pop;
    imm_back_stat_t   back_stat;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        inner_length_next = inner_length_reg;
        if (cfg_write && (reg_idx == REG_INNER_LENGTH))
        begin
            inner_length_next = pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_INNER_LENGTH:
            begin
                prdata = PDATA_W'(inner_length_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_length_reg <= INNER_LENGTH_RESET;
        end
        else
        begin
            inner_length_reg <= inner_length_next;
        end
    end

    imm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    imm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .inner_length (inner_length_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .stat         (back_stat)
    );

    // Engine never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // MAC pipeline drains before the engine goes idle
    assert property (@(posedge clk) disable iff (!rst_n) !back_stat.busy |-> !back_stat.mac_active)
        else $error("MAC pipeline active while engine idle");

    // A new result only appears as the engine leaves a compute
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(back_stat.busy) && !back_stat.busy)
        else $error("result raised without a finished compute");

endmodule

@@ rtl/imm_ram.sv @@
`timescale 1ns / 1ps

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/imm_front.sv @@
`timescale 1ns / 1ps

module imm_front
    import imm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  imm_in_t  item,
    output logic     cmd_valid,
    output imm_cmd_t cmd,
    input  logic     cmd_pop
);

    imm_cmd_t          q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic     accept;
    logic     keep;
    imm_cmd_t new_cmd;
    logic     push;
    logic     pop;

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept     = item_valid && !item_stall;

    // Classify: drop unused types and out-of-range writes
    always_comb
    begin
        new_cmd.row      = item.row_index;
        new_cmd.col      = item.column_index;
        new_cmd.value    = item.element_value;
        new_cmd.op       = OP_CALC;
        new_cmd.in_range = 1'b0;
        keep             = 1'b0;
        case (item.req_type)
            REQ_WRITE_A:
            begin
                new_cmd.op = OP_WR_A;
                keep = (item.row_index < ROWS_A) && (item.column_index < INNER_MAX);
            end
            REQ_WRITE_B:
            begin
                new_cmd.op = OP_WR_B;
                keep = (item.row_index < INNER_MAX) && (item.column_index < COLS_B);
            end
            REQ_COMPUTE:
            begin
                new_cmd.op       = OP_CALC;
                new_cmd.in_range = (item.row_index < ROWS_A) && (item.column_index < COLS_B);
                keep             = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;
    assign pop  = cmd_pop && cmd_valid;

    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ rtl/imm_back.sv @@
`timescale 1ns / 1ps

module imm_back
    import imm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [LEN_W-1:0] inner_length,
    input  logic           cmd_valid,
    input  imm_cmd_t       cmd,
    output logic           cmd_pop,
    output logic           result_valid,
    input  logic           result_stall,
    output imm_out_t       result,
    output imm_back_stat_t stat
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic               state_reg, state_next;
    logic [K_CNT_W-1:0] k_reg, k_next;
    logic [K_CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   col_reg, col_next;
    logic               rd_v_reg, rd_v_next;
    logic               prod_v_reg, prod_v_next;
    logic [DATA_W-1:0]  prod_reg, prod_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    imm_out_t           out_reg;

    logic                we_a, we_b;
    logic                mac_issue;
    logic                calc_start;
    logic                load_out;
    logic [K_CNT_W-1:0]  sat_len;
    logic [K_W-1:0]      k_idx;
    logic [A_ADDR_W-1:0] a_waddr, a_raddr;
    logic [B_ADDR_W-1:0] b_waddr, b_raddr;
    logic [DATA_W-1:0]   a_rdata, b_rdata;

    assign sat_len = (32'(inner_length) > INNER_MAX) ? K_CNT_W'(INNER_MAX)
                                                      : K_CNT_W'(inner_length);
    assign k_idx   = k_reg[K_W-1:0];

    assign a_waddr = A_ADDR_W'(32'(cmd.row) * INNER_MAX + 32'(cmd.col));
    assign b_waddr = B_ADDR_W'(32'(cmd.row) * COLS_B + 32'(cmd.col));
    assign a_raddr = A_ADDR_W'(32'(row_reg) * INNER_MAX + 32'(k_idx));
    assign b_raddr = B_ADDR_W'(32'(k_idx) * COLS_B + 32'(col_reg));

    imm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (A_DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (a_waddr),
        .wdata (cmd.value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (B_DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (b_waddr),
        .wdata (cmd.value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        len_next   = len_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd_pop    = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        mac_issue  = 1'b0;
        calc_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_WR_A:
                        begin
                            we_a = 1'b1;
                        end
                        OP_WR_B:
                        begin
                            we_b = 1'b1;
                        end
                        OP_CALC:
                        begin
                            calc_start = 1'b1;
                            row_next   = cmd.row;
                            col_next   = cmd.col;
                            len_next   = cmd.in_range ? sat_len : '0;
                            k_next     = '0;
                            state_next = S_RUN;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (k_reg < len_reg)
                begin
                    mac_issue = 1'b1;
                    k_next    = k_reg + 1'b1;
                end
                else if (!rd_v_reg && !prod_v_reg && (!out_valid_reg || !result_stall))
                begin
                    // Sum complete: move it to the output register
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_v_next   = mac_issue;
    assign prod_v_next = rd_v_reg;
    assign prod_next   = a_rdata * b_rdata;

    always_comb
    begin
        acc_next = acc_reg;
        if (calc_start)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            len_reg       <= '0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            rd_v_reg      <= rd_v_next;
            prod_v_reg    <= prod_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (load_out)
        begin
            out_reg.result_row    <= row_reg;
            out_reg.result_column <= col_reg;
            out_reg.dot_sum       <= $signed(acc_reg);
        end
    end

    assign result_valid    = out_valid_reg;
    assign result          = out_reg;
    assign stat.busy       = (state_reg == S_RUN);
    assign stat.mac_active = rd_v_reg || prod_v_reg;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import imm_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_INNER_LENGTH = {REG_INNER_LENGTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_INNER_LENGTH, 2'b00};

    localparam int MAX_PAUSE = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = INNER_MAX + 24;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int PHASE_COUNT = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    imm_in_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    imm_out_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Mirror of the matrix stores and the length register
    logic [DATA_W-1:0] mirror_a [ROWS_A][INNER_MAX];
    logic [DATA_W-1:0] mirror_b [INNER_MAX][COLS_B];
    bit a_written [ROWS_A][INNER_MAX];
    bit b_written [INNER_MAX][COLS_B];
    logic [LEN_W-1:0] inner_length = INNER_LENGTH_RESET;
    imm_out_t pending_sums [$];

    bit pauses_on = 1'b1;
    bit hold_results = 1'b0;
    int error_count = 0;
    int writes_sent = 0;
    int computes_sent = 0;
    int dropped_sent = 0;
    int results_checked = 0;
    int lengths_tried = 0;
    int input_stall_cycles = 0;

    integer_matrix_multiply_unit dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic imm_in_t make_request(input logic [TYPE_W-1:0] kind, input int row,
                                             input int col, input logic [DATA_W-1:0] value);
        imm_in_t req;
        req.req_type = kind;
        req.row_index = IDX_W'(row);
        req.column_index = IDX_W'(col);
        req.element_value = value;
        return req;
    endfunction

    function automatic int terms_used();
        return (inner_length > INNER_MAX) ? INNER_MAX : int'(inner_length);
    endfunction

    function automatic bit row_ready(input int r);
        for (int k = 0; k < terms_used(); k++)
            if (!a_written[r][k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit col_ready(input int c);
        for (int k = 0; k < terms_used(); k++)
            if (!b_written[k][c])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] dot_product_of(input int r, input int c);
        logic [DATA_W-1:0] acc;
        acc = '0;
        // 32-bit context keeps the wrap modulo 2^32
        for (int k = 0; k < terms_used(); k++)
            acc = acc + mirror_a[r][k] * mirror_b[k][c];
        return acc;
    endfunction

    task automatic mirror_request(input imm_in_t req);
        imm_out_t sum;
        case (req.req_type)
            REQ_WRITE_A:
            begin
                mirror_a[req.row_index][req.column_index] = req.element_value;
                a_written[req.row_index][req.column_index] = 1'b1;
                writes_sent++;
            end
            REQ_WRITE_B:
            begin
                mirror_b[req.row_index][req.column_index] = req.element_value;
                b_written[req.row_index][req.column_index] = 1'b1;
                writes_sent++;
            end
            REQ_COMPUTE:
            begin
                sum.result_row = req.row_index;
                sum.result_column = req.column_index;
                sum.dot_sum = dot_product_of(req.row_index, req.column_index);
                pending_sums.push_back(sum);
                computes_sent++;
            end
            default:
                dropped_sent++;
        endcase
    endtask

    task automatic send_request(input imm_in_t req);
        int pause;
        pause = pauses_on ? $urandom_range(0, MAX_PAUSE) : 0;
        if (pause > 0)
        begin
            item_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        item <= req;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        mirror_request(req);
    endtask

    task automatic wait_until_idle(input int limit);
        int waited;
        waited = 0;
        item_valid <= 1'b0;
        while (pending_sums.size() != 0 && waited < limit)
        begin
            @(posedge clk);
            waited++;
        end
        // let trailing writes drain from the command queue
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        bit done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            data = prdata;
            done = pready;
            @(posedge clk);
        end while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_length_readback(input logic [LEN_W-1:0] want);
        logic [PDATA_W-1:0] readback;
        apb_read(ADDR_INNER_LENGTH, readback);
        if (readback[LEN_W-1:0] !== want)
        begin
            $display("%0t: inner_length readback expected %0d actual %0d",
                     $time, want, readback[LEN_W-1:0]);
            error_count++;
        end
    endtask

    task automatic set_inner_length(input logic [LEN_W-1:0] len);
        logic [PDATA_W-1:0] word;
        wait_until_idle(IDLE_LIMIT);
        // upper bits are junk and must be dropped by the register
        word = $urandom();
        word[LEN_W-1:0] = len;
        apb_write(ADDR_INNER_LENGTH, word);
        inner_length = len;
        lengths_tried++;
        check_length_readback(len);
    endtask

    task automatic pick_request(input int compute_pct, output imm_in_t req);
        int ready_rows [$];
        int ready_cols [$];
        int r;
        int c;
        bit found;
        logic [DATA_W-1:0] v;
        logic [TYPE_W-1:0] kind;
        for (int i = 0; i < ROWS_A; i++)
            if (row_ready(i))
                ready_rows.push_back(i);
        for (int i = 0; i < COLS_B; i++)
            if (col_ready(i))
                ready_cols.push_back(i);
        case ($urandom_range(0, 14))
            0: v = '0;
            1: v = 32'd1;
            2: v = '1;
            3: v = 32'h7FFF_FFFF;
            4: v = 32'h8000_0000;
            default: v = $urandom();
        endcase
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
        if ($urandom_range(0, 99) < 4)
        begin
            req = make_request(REQ_UNUSED, r, c, v);
        end
        else if (ready_rows.size() > 0 && ready_cols.size() > 0
                 && $urandom_range(0, 99) < compute_pct)
        begin
            r = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
            c = ready_cols[$urandom_range(0, ready_cols.size() - 1)];
            req = make_request(REQ_COMPUTE, r, c, v);
        end
        else
        begin
            kind = ($urandom_range(0, 1) == 1) ? REQ_WRITE_B : REQ_WRITE_A;
            // mostly fill the lowest gap so whole rows and columns become usable
            if ($urandom_range(0, 9) < 7)
            begin
                found = 1'b0;
                if (kind == REQ_WRITE_A)
                begin
                    if ($urandom_range(0, 1) == 1)
                        for (int i = 0; i < ROWS_A; i++)
                            if (!found && !row_ready(i))
                            begin
                                r = i;
                                found = 1'b1;
                            end
                    for (int k = terms_used() - 1; k >= 0; k--)
                        if (!a_written[r][k])
                            c = k;
                end
                else
                begin
                    if ($urandom_range(0, 1) == 1)
                        for (int i = 0; i < COLS_B; i++)
                            if (!found && !col_ready(i))
                            begin
                                c = i;
                                found = 1'b1;
                            end
                    for (int k = terms_used() - 1; k >= 0; k--)
                        if (!b_written[k][c])
                            r = k;
                end
            end
            req = make_request(kind, r, c, v);
        end
    endtask

    task automatic send_random_requests(input int count, input int compute_pct);
        imm_in_t req;
        repeat (count)
        begin
            pick_request(compute_pct, req);
            send_request(req);
        end
    endtask

    task automatic test_directed_cases();
        check_length_readback(INNER_LENGTH_RESET);
        set_inner_length(5'd1);
        send_request(make_request(REQ_WRITE_A, 0, 0, 32'h7FFF_FFFF));
        send_request(make_request(REQ_WRITE_B, 0, 0, 32'h8000_0000));
        send_request(make_request(REQ_COMPUTE, 0, 0, '0));
        set_inner_length(5'd2);
        // unmapped register: the length must stay at two
        apb_write(ADDR_SPARE, 32'h0000_0007);
        send_request(make_request(REQ_WRITE_A, 0, 1, '1));
        send_request(make_request(REQ_WRITE_B, 1, 0, '1));
        send_request(make_request(REQ_COMPUTE, 0, 0, '1));
        send_request(make_request(REQ_WRITE_A, 15, 0, 32'h8000_0000));
        send_request(make_request(REQ_WRITE_A, 15, 1, 32'h8000_0000));
        send_request(make_request(REQ_WRITE_B, 0, 15, 32'h8000_0000));
        send_request(make_request(REQ_WRITE_B, 1, 15, 32'd1));
        send_request(make_request(REQ_COMPUTE, 15, 15, 32'h5555_5555));
        send_request(make_request(REQ_COMPUTE, 0, 15, 32'hAAAA_AAAA));
        send_request(make_request(REQ_COMPUTE, 15, 0, '0));
        // unused type: dropped, no result
        send_request(make_request(REQ_UNUSED, 15, 15, '1));
        set_inner_length(5'd0);
        send_request(make_request(REQ_COMPUTE, 9, 6, '0));
        send_request(make_request(REQ_COMPUTE, 15, 0, '1));
    endtask

    task automatic test_random_lengths();
        logic [LEN_W-1:0] lengths [PHASE_COUNT];
        lengths = '{5'd3, 5'd8, 5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd12};
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_inner_length(lengths[p]);
            send_random_requests(ITEMS_PER_PHASE, 40);
        end
    endtask

    task automatic test_result_backpressure();
        set_inner_length(5'd4);
        hold_results = 1'b1;
        pauses_on = 1'b0;
        send_random_requests(40, 90);
        pauses_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        pauses_on = 1'b0;
        send_random_requests(60, 40);
        pauses_on = 1'b1;
    endtask

    // Receiver: random stall before each transfer, one long hold on request
    initial
    begin : result_pacing
        int pause;
        while (!rst_n) @(posedge clk);
        forever
        begin
            pause = pauses_on ? $urandom_range(0, MAX_PAUSE) : 0;
            if (hold_results)
            begin
                pause += HOLD_CYCLES;
                hold_results = 1'b0;
            end
            if (pause > 0)
            begin
                result_stall <= 1'b1;
                repeat (pause) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin : check_results
        imm_out_t want;
        if (rst_n && item_valid && item_stall)
            input_stall_cycles++;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result row %0d column %0d sum %0d", $time,
                         result.result_row, result.result_column, result.dot_sum);
                error_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                results_checked++;
                if (result.result_row !== want.result_row)
                begin
                    $display("%0t: result_row expected %0d actual %0d", $time,
                             want.result_row, result.result_row);
                    error_count++;
                end
                if (result.result_column !== want.result_column)
                begin
                    $display("%0t: result_column expected %0d actual %0d", $time,
                             want.result_column, result.result_column);
                    error_count++;
                end
                if (result.dot_sum !== want.dot_sum)
                begin
                    $display("%0t: dot_sum of C[%0d][%0d] expected %0d actual %0d", $time,
                             want.result_row, want.result_column, want.dot_sum,
                             result.dot_sum);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_lengths();
        test_result_backpressure();
        test_back_to_back();
        wait_until_idle(IDLE_LIMIT);
        if (pending_sums.size() != 0)
        begin
            $display("%0t: %0d results never arrived, first C[%0d][%0d] expected %0d", $time,
                     pending_sums.size(), pending_sums[0].result_row,
                     pending_sums[0].result_column, pending_sums[0].dot_sum);
            error_count++;
        end
        $display("Sent %0d element writes, %0d dot-product requests, %0d dropped requests",
                 writes_sent, computes_sent, dropped_sent);
        $display("over %0d length settings; %0d results checked, input held off %0d cycles",
                 lengths_tried, results_checked, input_stall_cycles);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("%0t: run timed out", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/imm_pkg.sv
rtl/imm_ram.sv
rtl/imm_front.sv
rtl/imm_back.sv
rtl/integer_matrix_multiply_unit.sv
verif/tb_top.sv
